// ----- sv/particle_boundary_collision_macros.svh -----
// Assertion macros for the particle boundary collision block.
// Used by modules that have i_clk and i_rst_n in scope.
`ifndef PARTICLE_BOUNDARY_COLLISION_MACROS_SVH
`define PARTICLE_BOUNDARY_COLLISION_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define PBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbc assertion failed");

// Check that cons holds in the cycle after ante
`define PBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbc assertion failed");

`endif

// ----- sv/pbc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the boundary collision pipeline.
// No dependencies.
package pbc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CIRCLE_EN = 3'd0;
    localparam logic [2:0] REG_CENTER_X  = 3'd1;
    localparam logic [2:0] REG_CENTER_Y  = 3'd2;
    localparam logic [2:0] REG_DAMPING   = 3'd3;
    localparam logic [2:0] REG_X_MIN     = 3'd4;
    localparam logic [2:0] REG_X_MAX     = 3'd5;
    localparam logic [2:0] REG_Y_MIN     = 3'd6;
    localparam logic [2:0] REG_Y_MAX     = 3'd7;

    // Ring radius 455 in Q11.8 and its square
    localparam logic [16:0] RING_Q  = 17'd116480;
    localparam logic [41:0] RING_Q2 = 42'd13567590400;

    localparam logic [8:0]  DAMP_RESET = 9'd230;
    localparam logic [19:0] BOUND_MAX_RESET = 20'd262144;

    typedef logic signed [19:0] t_q;

    typedef struct packed {
        logic               valid;
        logic               outside;
        t_q                 px;
        t_q                 py;
        t_q                 vx;
        t_q                 vy;
        t_q                 rvx;
        t_q                 rvy;
        logic signed [20:0] dx;
        logic signed [20:0] dy;
        logic [40:0]        sqx;
        logic [40:0]        sqy;
        logic [36:0]        magx;
        logic [36:0]        magy;
        logic [41:0]        d2;
        logic [23:0]        srem;
        logic [20:0]        root;
        logic [37:0]        remx;
        logic [37:0]        remy;
        logic [16:0]        qx;
        logic [16:0]        qy;
        logic signed [29:0] prx;
        logic signed [29:0] pry;
        logic               ltx;
        logic               gtx;
        logic               lty;
        logic               gty;
    } t_pipe;

    // Saturate to the signed 20-bit range
    function automatic t_q sat20(input logic signed [31:0] x);
        t_q r;
        if (x > 32'sd524287) begin
            r = 20'sh7FFFF;
        end else if (x < -32'sd524288) begin
            r = 20'sh80000;
        end else begin
            r = 20'(x);
        end
        return r;
    endfunction

    // Round a Q.8 product half up and saturate
    function automatic t_q round_sat(input logic signed [29:0] p);
        logic signed [31:0] t;
        t = (32'(p) + 32'sd128) >>> 8;
        return sat20(t);
    endfunction

    // Negated product of velocity and damping
    function automatic logic signed [29:0] neg_damp(input t_q v, input logic [8:0] d);
        logic signed [29:0] m;
        m = 30'(v) * $signed({21'd0, d});
        return -m;
    endfunction

endpackage

// ----- sv/pbc_sqrt_step.sv -----
// One digit step of the integer square root of the squared distance.
// Depends on pbc_pkg.
module pbc_sqrt_step import pbc_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_pipe i_item,
    output t_pipe o_item
);

    logic [23:0] rem_sh;
    logic [23:0] trial;
    logic        ge;
    t_pipe       n_item;
    t_pipe       r_item;

    // Bring down two bits and try the next root bit
    always_comb begin
        rem_sh = {i_item.srem[21:0], i_item.d2[2*STEP+1 -: 2]};
        trial  = {1'b0, i_item.root, 2'b01};
        ge     = rem_sh >= trial;
        n_item = i_item;
        n_item.srem = ge ? rem_sh - trial : rem_sh;
        n_item.root = {i_item.root[19:0], ge};
    end

    // Advance the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ----- sv/pbc_div_step.sv -----
// One quotient bit of the scale to ring division, both axes.
// Depends on pbc_pkg.
module pbc_div_step import pbc_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_pipe i_item,
    output t_pipe o_item
);

    logic [37:0] sh;
    logic        gex;
    logic        gey;
    t_pipe       n_item;
    t_pipe       r_item;

    // Subtract the shifted divisor where it fits
    always_comb begin
        sh     = 38'(i_item.root) << BIT;
        gex    = i_item.remx >= sh;
        gey    = i_item.remy >= sh;
        n_item = i_item;
        n_item.remx   = gex ? i_item.remx - sh : i_item.remx;
        n_item.remy   = gey ? i_item.remy - sh : i_item.remy;
        n_item.qx[BIT] = gex;
        n_item.qy[BIT] = gey;
    end

    // Advance the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ----- sv/pbc_clamp.sv -----
// Ring projection select, box clamp and damped reflections: five stages.
// Depends on pbc_pkg.
module pbc_clamp import pbc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_q         i_center_x,
    input  t_q         i_center_y,
    input  logic [8:0] i_damping,
    input  t_q         i_x_min,
    input  t_q         i_x_max,
    input  t_q         i_y_min,
    input  t_q         i_y_max,
    input  t_pipe      i_item,
    output t_pipe      o_item
);

    t_pipe n_p, r_p;
    t_pipe n_c1, r_c1;
    t_pipe n_c2, r_c2;
    t_pipe n_c3, r_c3;
    t_pipe n_c4, r_c4;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    t_q p1x;
    t_q p1y;

    // Place the particle on the ring and take the reflected velocity when it left the circle
    always_comb begin
        ex  = i_item.dx[20] ? -$signed({15'd0, i_item.qx}) : $signed({15'd0, i_item.qx});
        ey  = i_item.dy[20] ? -$signed({15'd0, i_item.qy}) : $signed({15'd0, i_item.qy});
        n_p = i_item;
        if (i_item.outside) begin
            n_p.px = sat20(32'(i_center_x) + ex);
            n_p.py = sat20(32'(i_center_y) + ey);
            n_p.vx = i_item.rvx;
            n_p.vy = i_item.rvy;
        end
    end

    // Decide min and max clamps, start the first reflection product
    always_comb begin
        n_c1 = r_p;
        n_c1.ltx = r_p.px < i_x_min;
        n_c1.lty = r_p.py < i_y_min;
        p1x = n_c1.ltx ? i_x_min : r_p.px;
        p1y = n_c1.lty ? i_y_min : r_p.py;
        n_c1.gtx = p1x > i_x_max;
        n_c1.gty = p1y > i_y_max;
        n_c1.px  = n_c1.gtx ? i_x_max : p1x;
        n_c1.py  = n_c1.gty ? i_y_max : p1y;
        n_c1.prx = neg_damp(r_p.vx, i_damping);
        n_c1.pry = neg_damp(r_p.vy, i_damping);
    end

    // Apply the min reflection
    always_comb begin
        n_c2 = r_c1;
        if (r_c1.ltx) n_c2.vx = round_sat(r_c1.prx);
        if (r_c1.lty) n_c2.vy = round_sat(r_c1.pry);
    end

    // Second reflection product
    always_comb begin
        n_c3 = r_c2;
        n_c3.prx = neg_damp(r_c2.vx, i_damping);
        n_c3.pry = neg_damp(r_c2.vy, i_damping);
    end

    // Apply the max reflection
    always_comb begin
        n_c4 = r_c3;
        if (r_c3.gtx) n_c4.vx = round_sat(r_c3.prx);
        if (r_c3.gty) n_c4.vy = round_sat(r_c3.pry);
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p.valid  <= 1'b0;
            r_c1.valid <= 1'b0;
            r_c2.valid <= 1'b0;
            r_c3.valid <= 1'b0;
            r_c4.valid <= 1'b0;
        end else if (i_en) begin
            r_p  <= n_p;
            r_c1 <= n_c1;
            r_c2 <= n_c2;
            r_c3 <= n_c3;
            r_c4 <= n_c4;
        end
    end

    assign o_item = r_c4;

endmodule

// ----- sv/particle_boundary_collision.sv -----
// Particle boundary collision: ring reflection and projection, then box clamp.
// One transaction per cycle while the output is not stalled.
// The depth is mostly set by the 21 square root digit stages and 17 quotient bit stages.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and loads register defaults.
`include "particle_boundary_collision_macros.svh"
module particle_boundary_collision import pbc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_q          i_pos_x,
    input  t_q          i_pos_y,
    input  t_q          i_vel_x,
    input  t_q          i_vel_y,
    output logic        o_valid,
    input  logic        i_stall,
    output t_q          o_new_pos_x,
    output t_q          o_new_pos_y,
    output t_q          o_new_vel_x,
    output t_q          o_new_vel_y,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [19:0] i_cfg_data
);

    logic       r_circle_enable;
    t_q         r_center_x;
    t_q         r_center_y;
    logic [8:0] r_damping;
    t_q         r_x_min;
    t_q         r_x_max;
    t_q         r_y_min;
    t_q         r_y_max;

    logic  en;
    t_pipe n_s1, r_s1;
    t_pipe n_s2, r_s2;
    t_pipe n_s3, r_s3;
    t_pipe n_sn, r_sn;
    t_pipe w_sq [22];
    t_pipe w_dv [18];
    t_pipe w_out;
    logic [20:0] absdx;
    logic [20:0] absdy;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circle_enable <= 1'b0;
            r_center_x      <= '0;
            r_center_y      <= '0;
            r_damping       <= DAMP_RESET;
            r_x_min         <= '0;
            r_x_max         <= BOUND_MAX_RESET;
            r_y_min         <= '0;
            r_y_max         <= BOUND_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CIRCLE_EN: r_circle_enable <= i_cfg_data[0];
                REG_CENTER_X:  r_center_x      <= i_cfg_data;
                REG_CENTER_Y:  r_center_y      <= i_cfg_data;
                REG_DAMPING:   r_damping       <= i_cfg_data[8:0];
                REG_X_MIN:     r_x_min         <= i_cfg_data;
                REG_X_MAX:     r_x_max         <= i_cfg_data;
                REG_Y_MIN:     r_y_min         <= i_cfg_data;
                REG_Y_MAX:     r_y_max         <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Hold every stage while the result waits
    assign en      = !(w_out.valid && i_stall);
    assign o_stall = w_out.valid && i_stall;

    // Capture the transaction: offsets from center, ring reflection product
    always_comb begin
        n_s1       = '0;
        n_s1.valid = i_valid;
        n_s1.px    = i_pos_x;
        n_s1.py    = i_pos_y;
        n_s1.vx    = i_vel_x;
        n_s1.vy    = i_vel_y;
        n_s1.dx    = 21'(i_pos_x) - 21'(r_center_x);
        n_s1.dy    = 21'(i_pos_y) - 21'(r_center_y);
        n_s1.prx   = neg_damp(i_vel_x, r_damping);
        n_s1.pry   = neg_damp(i_vel_y, r_damping);
    end

    // Squares, scaled magnitudes, rounded ring reflection
    always_comb begin
        absdx = r_s1.dx[20] ? 21'(-r_s1.dx) : 21'(r_s1.dx);
        absdy = r_s1.dy[20] ? 21'(-r_s1.dy) : 21'(r_s1.dy);
        n_s2 = r_s1;
        n_s2.sqx  = 41'(42'(r_s1.dx) * 42'(r_s1.dx));
        n_s2.sqy  = 41'(42'(r_s1.dy) * 42'(r_s1.dy));
        n_s2.magx = 37'(absdx) * 37'(RING_Q);
        n_s2.magy = 37'(absdy) * 37'(RING_Q);
        n_s2.rvx  = round_sat(r_s1.prx);
        n_s2.rvy  = round_sat(r_s1.pry);
    end

    // Squared distance and the outside test
    always_comb begin
        n_s3 = r_s2;
        n_s3.d2      = 42'(r_s2.sqx) + 42'(r_s2.sqy);
        n_s3.outside = r_circle_enable && (n_s3.d2 > RING_Q2);
        n_s3.srem    = '0;
        n_s3.root    = '0;
    end

    assign w_sq[0] = r_s3;

    // Square root, one digit per stage
    for (genvar g = 0; g < 21; g++) begin : g_sqrt
        pbc_sqrt_step #(.STEP(20 - g)) u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_item  (w_sq[g]),
            .o_item  (w_sq[g+1])
        );
    end

    // Dividends with half the divisor added for rounding
    always_comb begin
        n_sn = w_sq[21];
        n_sn.remx = 38'(w_sq[21].magx) + 38'(w_sq[21].root[20:1]);
        n_sn.remy = 38'(w_sq[21].magy) + 38'(w_sq[21].root[20:1]);
        n_sn.qx   = '0;
        n_sn.qy   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_sn.valid <= 1'b0;
        end else if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_sn <= n_sn;
        end
    end

    assign w_dv[0] = r_sn;

    // Division, one quotient bit per stage
    for (genvar g = 0; g < 17; g++) begin : g_div
        pbc_div_step #(.BIT(16 - g)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_item  (w_dv[g]),
            .o_item  (w_dv[g+1])
        );
    end

    pbc_clamp u_clamp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_damping  (r_damping),
        .i_x_min    (r_x_min),
        .i_x_max    (r_x_max),
        .i_y_min    (r_y_min),
        .i_y_max    (r_y_max),
        .i_item     (w_dv[17]),
        .o_item     (w_out)
    );

    assign o_valid     = w_out.valid;
    assign o_new_pos_x = w_out.px;
    assign o_new_pos_y = w_out.py;
    assign o_new_vel_x = w_out.vx;
    assign o_new_vel_y = w_out.vy;

    // An accepted transaction lands in the first stage
    `PBC_ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, r_s1.valid)
    // A stall freezes the first stage
    `PBC_ASSERT_NEXT(a_stall_holds, o_stall, $stable(r_s1.valid) && $stable(r_s1.px))
    // The root is the floor square root of the squared distance
    `PBC_ASSERT_NOW(a_root_floor, w_sq[21].valid,
        (64'(w_sq[21].root) * 64'(w_sq[21].root) <= 64'(w_sq[21].d2)) &&
        ((64'(w_sq[21].root) + 64'd1) * (64'(w_sq[21].root) + 64'd1) > 64'(w_sq[21].d2)))

endmodule

// ----- dv/particle_boundary_collision_tb.sv -----
// Testbench for particle_boundary_collision: streams particles through the
// collision pipeline, predicts each corrected particle and compares field by field.
// Depends on pbc_pkg and the particle_boundary_collision RTL.
module particle_boundary_collision_tb import pbc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = 47;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint RING_SQ = 64'd13567590400;

    typedef struct {
        t_q px;
        t_q py;
        t_q vx;
        t_q vy;
    } t_particle;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_q          i_pos_x = '0;
    t_q          i_pos_y = '0;
    t_q          i_vel_x = '0;
    t_q          i_vel_y = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_q          o_new_pos_x;
    t_q          o_new_pos_y;
    t_q          o_new_vel_x;
    t_q          o_new_vel_y;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [19:0] i_cfg_data = '0;

    // Shadow copy of the configuration registers
    logic        circle_on;
    longint      ctr_x, ctr_y, damp, box_x_lo, box_x_hi, box_y_lo, box_y_hi;

    t_particle pending_q[$];
    t_particle expected_q[$];
    int        mismatch_cnt = 0;
    int        idle_cnt = 0;
    bit        calm = 1'b0;

    particle_boundary_collision dut (.*);

    always #1 i_clk = ~i_clk;

    task automatic report(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic longint sat_q(input longint x);
        if (x > 524287) return 524287;
        if (x < -524288) return -524288;
        return x;
    endfunction

    // Negate, scale by damping, round half up, saturate
    function automatic longint bounce(input longint v);
        longint p;
        p = -v * damp;
        if (p >= 0) return sat_q((p + 128) >>> 8);
        return sat_q(-((-p + 127) >>> 8));
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint onto_ring(input longint d, input longint span);
        longint m, q;
        m = (d < 0 ? -d : d) * 116480;
        q = (m + span / 2) / span;
        return d < 0 ? -q : q;
    endfunction

    function automatic t_particle collide(input t_particle p);
        t_particle r;
        longint px, py, vx, vy, dx, dy, d2, root_len;
        px = p.px; py = p.py; vx = p.vx; vy = p.vy;
        if (circle_on) begin
            dx = px - ctr_x;
            dy = py - ctr_y;
            d2 = dx * dx + dy * dy;
            if (d2 > RING_SQ) begin
                root_len = int_sqrt(d2);
                vx = bounce(vx);
                vy = bounce(vy);
                px = sat_q(ctr_x + onto_ring(dx, root_len));
                py = sat_q(ctr_y + onto_ring(dy, root_len));
            end
        end
        if (px < box_x_lo) begin vx = bounce(vx); px = box_x_lo; end
        if (px > box_x_hi) begin vx = bounce(vx); px = box_x_hi; end
        if (py < box_y_lo) begin vy = bounce(vy); py = box_y_lo; end
        if (py > box_y_hi) begin vy = bounce(vy); py = box_y_hi; end
        r.px = t_q'(px); r.py = t_q'(py); r.vx = t_q'(vx); r.vy = t_q'(vy);
        return r;
    endfunction

    // Write one register and mirror it; only called while idle
    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CIRCLE_EN: circle_on = val[0];
            REG_CENTER_X:  ctr_x = longint'(signed'(val));
            REG_CENTER_Y:  ctr_y = longint'(signed'(val));
            REG_DAMPING:   damp = val[8:0];
            REG_X_MIN:     box_x_lo = longint'(signed'(val));
            REG_X_MAX:     box_x_hi = longint'(signed'(val));
            REG_Y_MIN:     box_y_lo = longint'(signed'(val));
            REG_Y_MAX:     box_y_hi = longint'(signed'(val));
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
    endtask

    function automatic t_q rnd_q();
        case ($urandom_range(0, 4))
            0: return t_q'($urandom);
            1: return t_q'($urandom_range(0, 1) ? 20'h7FFFF : 20'h80000);
            2: return t_q'(int'($urandom_range(0, 180000)) - 30000);
            default: return t_q'(int'($urandom_range(0, 300000)) - 20000);
        endcase
    endfunction

    task automatic push_item(input t_q px, input t_q py, input t_q vx, input t_q vy);
        t_particle p;
        p.px = px; p.py = py; p.vx = vx; p.vy = vy;
        pending_q = {pending_q, p};
    endtask

    // Driver: offer the head of the pending queue, hold while stalled
    always @(posedge i_clk) begin
        t_particle nxt;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                nxt = pending_q.pop_front();
                expected_q = {expected_q, collide(nxt)};
            end
            if ((!i_valid || !o_stall) && pending_q.size() > 0 &&
                (i_valid && !o_stall ? pending_q.size() > 0 : 1'b1)) begin
                if (calm || $urandom_range(0, 99) >= 31) begin
                    i_valid <= 1'b1;
                    i_pos_x <= pending_q[0].px;
                    i_pos_y <= pending_q[0].py;
                    i_vel_x <= pending_q[0].vx;
                    i_vel_y <= pending_q[0].vy;
                end else begin
                    i_valid <= 1'b0;
                end
            end else if (!i_valid || !o_stall) begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_particle e;
        if (i_rst_n) begin
            i_stall <= !calm && ($urandom_range(0, 99) < 31);
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result transaction", 0, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (o_new_pos_x !== e.px) report("new_pos_x", o_new_pos_x, e.px);
                    if (o_new_pos_y !== e.py) report("new_pos_y", o_new_pos_y, e.py);
                    if (o_new_vel_x !== e.vx) report("new_vel_x", o_new_vel_x, e.vx);
                    if (o_new_vel_y !== e.vy) report("new_vel_y", o_new_vel_y, e.vy);
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cnt <= 0;
        end else if (pending_q.size() > 0 || expected_q.size() > 0) begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            push_item(rnd_q(), rnd_q(), rnd_q(), rnd_q());
        end
        drain();
    endtask

    initial begin
        circle_on = 1'b0; ctr_x = 0; ctr_y = 0; damp = 230;
        box_x_lo = 0; box_x_hi = 262144; box_y_lo = 0; box_y_hi = 262144;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, extremes and both box sides
        push_item(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 20'sh80000);
        push_item(20'sh80000, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF);
        push_item(t_q'(1000), t_q'(2000), t_q'(-300), t_q'(77));
        push_item(t_q'(0), t_q'(262144), t_q'(5), t_q'(-5));
        push_item(t_q'(-1), t_q'(262145), t_q'(256), t_q'(-256));
        drain();

        // Circle on, center in box; on-circle and just outside, inverted-free
        write_reg(REG_CIRCLE_EN, 20'd1);
        write_reg(REG_CENTER_X, 20'd131072);
        write_reg(REG_CENTER_Y, 20'd131072);
        write_reg(REG_DAMPING, 20'd256);
        write_reg(REG_X_MIN, 20'h80000);
        write_reg(REG_X_MAX, 20'h7FFFF);
        write_reg(REG_Y_MIN, 20'h80000);
        write_reg(REG_Y_MAX, 20'h7FFFF);
        push_item(t_q'(131072 + 116480), t_q'(131072), t_q'(100), t_q'(-100));
        push_item(t_q'(131072 + 116481), t_q'(131072), t_q'(100), t_q'(-100));
        push_item(t_q'(131072 - 90000), t_q'(131072 - 90000), t_q'(-7), t_q'(9));
        push_item(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 20'sh80000);
        push_item(t_q'(131072), t_q'(131072), t_q'(1), t_q'(1));
        drain();

        // Projection then clamp, damping above one, inverted bounds
        write_reg(REG_DAMPING, 20'h1FF);
        write_reg(REG_CENTER_X, 20'h80000);
        write_reg(REG_CENTER_Y, 20'h7FFFF);
        write_reg(REG_X_MIN, 20'd200000);
        write_reg(REG_X_MAX, 20'd100000);
        write_reg(REG_Y_MIN, 20'd0);
        write_reg(REG_Y_MAX, 20'd50000);
        push_item(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 20'sh80000);
        push_item(t_q'(150000), t_q'(40000), t_q'(3000), t_q'(-3000));
        push_item(t_q'(-400000), t_q'(400000), t_q'(-1), t_q'(0));
        push_item(t_q'(0), t_q'(0), t_q'(0), t_q'(0));
        drain();

        // Damping zero, unused high data bits
        write_reg(REG_DAMPING, 20'hFFE00);
        write_reg(REG_CIRCLE_EN, 20'hFFFFE);
        push_item(t_q'(-5), t_q'(60000), t_q'(123), t_q'(-123));
        push_item(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
        drain();

        // Random phases over several configurations
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_CIRCLE_EN, 20'($urandom_range(0, 1) | (ph % 2)));
            write_reg(REG_CENTER_X, 20'(int'($urandom_range(0, 262144))));
            write_reg(REG_CENTER_Y, 20'(int'($urandom_range(0, 262144))));
            write_reg(REG_DAMPING, 20'($urandom_range(0, ph == 5 ? 511 : 256)));
            write_reg(REG_X_MIN, 20'(int'($urandom_range(0, 60000)) - 20000));
            write_reg(REG_X_MAX, 20'(int'($urandom_range(160000, 300000))));
            write_reg(REG_Y_MIN, 20'(int'($urandom_range(0, 60000)) - 20000));
            write_reg(REG_Y_MAX, 20'(int'($urandom_range(160000, 300000))));
            calm = (ph == 2);
            random_phase(210);
        end
        calm = 1'b0;

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
